// File: hw/rtl/kdpl_pkg.sv
`default_nettype none

package kdpl_pkg;

    // Width of the millisecond stamps; ticks are used modulo 2^TICK_BITS
    localparam int TICK_BITS   = 32;
    localparam int NUM_KEYS    = 8;
    localparam int NUM_BUTTONS = 4;
    localparam int NUM_DIRS    = NUM_KEYS - NUM_BUTTONS;
    localparam int KEY_W       = $clog2(NUM_KEYS);
    localparam int DIR_W       = $clog2(NUM_DIRS);

    localparam int NOW_W   = 32;
    localparam int LOCK_W  = 16;
    localparam int CAL_W   = 12;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 3;
    // signed compare width, room for cal + margin and cal - margin
    localparam int CMP_W   = CAL_W + 2;

    typedef enum logic [1:0] {
        REQ_BUTTON = 2'd0,
        REQ_AXIS   = 2'd1,
        REQ_QUERY  = 2'd2,
        REQ_CLEAR  = 2'd3
    } t_req_type;

    localparam logic [CFG_IDX_W-1:0] CFG_BTN_LOCK  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LOCK = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_LOW     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_X_HIGH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_LOW     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_HIGH    = 3'd5;

    localparam logic [LOCK_W-1:0] BTN_LOCK_RST  = 16'd50;
    localparam logic [LOCK_W-1:0] AXIS_LOCK_RST = 16'd200;
    localparam logic [CAL_W-1:0]  CAL_LOW_RST   = 12'd0;
    localparam logic [CAL_W-1:0]  CAL_HIGH_RST  = 12'd4095;

    localparam logic signed [CMP_W-1:0] RIGHT_MARGIN = 14'sd300;
    localparam logic signed [CMP_W-1:0] LEFT_MARGIN  = 14'sd100;
    localparam logic signed [CMP_W-1:0] VERT_MARGIN  = 14'sd50;

    localparam logic [TICK_BITS-1:0] QUERY_HOLD_MS = TICK_BITS'(50);

    typedef struct packed {
        logic [LOCK_W-1:0] button_lockout_ms;
        logic [LOCK_W-1:0] axis_lockout_ms;
        logic [CAL_W-1:0]  x_low_cal;
        logic [CAL_W-1:0]  x_high_cal;
        logic [CAL_W-1:0]  y_low_cal;
        logic [CAL_W-1:0]  y_high_cal;
    } t_cfg;

    typedef struct packed {
        t_req_type         req_type;
        logic [KEY_W-1:0]  key_index;
        logic              button_level;
        logic [CAL_W-1:0]  axis_x;
        logic [CAL_W-1:0]  axis_y;
        logic [NOW_W-1:0]  now_ms;
    } t_req;

    typedef struct packed {
        logic                key_was_pressed;
        logic [NUM_KEYS-1:0] latch_mask;
    } t_rsp;

endpackage

`default_nettype wire

// File: hw/rtl/kdpl_cfg_regs.sv
`default_nettype none

module kdpl_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [kdpl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [kdpl_pkg::CFG_W-1:0]     i_cfg_wdata,
    output kdpl_pkg::t_cfg                      o_cfg
);

    kdpl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_lockout_ms <= kdpl_pkg::BTN_LOCK_RST;
            r_cfg.axis_lockout_ms   <= kdpl_pkg::AXIS_LOCK_RST;
            r_cfg.x_low_cal         <= kdpl_pkg::CAL_LOW_RST;
            r_cfg.x_high_cal        <= kdpl_pkg::CAL_HIGH_RST;
            r_cfg.y_low_cal         <= kdpl_pkg::CAL_LOW_RST;
            r_cfg.y_high_cal        <= kdpl_pkg::CAL_HIGH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kdpl_pkg::CFG_BTN_LOCK: begin
                    r_cfg.button_lockout_ms <= i_cfg_wdata[kdpl_pkg::LOCK_W-1:0];
                end
                kdpl_pkg::CFG_AXIS_LOCK: begin
                    r_cfg.axis_lockout_ms <= i_cfg_wdata[kdpl_pkg::LOCK_W-1:0];
                end
                kdpl_pkg::CFG_X_LOW: begin
                    r_cfg.x_low_cal <= i_cfg_wdata[kdpl_pkg::CAL_W-1:0];
                end
                kdpl_pkg::CFG_X_HIGH: begin
                    r_cfg.x_high_cal <= i_cfg_wdata[kdpl_pkg::CAL_W-1:0];
                end
                kdpl_pkg::CFG_Y_LOW: begin
                    r_cfg.y_low_cal <= i_cfg_wdata[kdpl_pkg::CAL_W-1:0];
                end
                kdpl_pkg::CFG_Y_HIGH: begin
                    r_cfg.y_high_cal <= i_cfg_wdata[kdpl_pkg::CAL_W-1:0];
                end
                default: begin
                    // unmapped index: write dropped
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: hw/rtl/kdpl_core.sv
`default_nettype none

module kdpl_core (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire kdpl_pkg::t_cfg i_cfg,
    input  wire kdpl_pkg::t_req i_req,
    output kdpl_pkg::t_rsp o_rsp
);

    logic [kdpl_pkg::TICK_BITS-1:0] r_stamps [kdpl_pkg::NUM_KEYS];
    logic [kdpl_pkg::TICK_BITS-1:0] n_stamps [kdpl_pkg::NUM_KEYS];
    logic [kdpl_pkg::NUM_KEYS-1:0]  r_latches;
    logic [kdpl_pkg::NUM_KEYS-1:0]  n_latches;

    logic [kdpl_pkg::TICK_BITS-1:0] now_t;
    logic [kdpl_pkg::TICK_BITS-1:0] btn_stamp;
    logic [kdpl_pkg::TICK_BITS-1:0] btn_age;
    logic [kdpl_pkg::TICK_BITS-1:0] btn_lock;
    logic [kdpl_pkg::TICK_BITS-1:0] axis_lock;
    logic [kdpl_pkg::TICK_BITS-1:0] dir_age [kdpl_pkg::NUM_DIRS];
    logic [kdpl_pkg::NUM_DIRS-1:0]  dir_down;
    logic signed [kdpl_pkg::CMP_W-1:0] x_s, y_s;
    logic signed [kdpl_pkg::CMP_W-1:0] xl_s, xh_s, yl_s, yh_s;
    logic answer;

    assign now_t     = kdpl_pkg::TICK_BITS'(i_req.now_ms);
    assign btn_lock  = kdpl_pkg::TICK_BITS'(i_cfg.button_lockout_ms);
    assign axis_lock = kdpl_pkg::TICK_BITS'(i_cfg.axis_lockout_ms);

    // only buttons use this age; bit 2 of the key is checked separately
    assign btn_stamp = r_stamps[{1'b0, i_req.key_index[kdpl_pkg::KEY_W-2:0]}];
    assign btn_age   = now_t - btn_stamp;

    assign x_s  = $signed({2'b00, i_req.axis_x});
    assign y_s  = $signed({2'b00, i_req.axis_y});
    assign xl_s = $signed({2'b00, i_cfg.x_low_cal});
    assign xh_s = $signed({2'b00, i_cfg.x_high_cal});
    assign yl_s = $signed({2'b00, i_cfg.y_low_cal});
    assign yh_s = $signed({2'b00, i_cfg.y_high_cal});

    // order: right, left, up, down
    assign dir_down[0] = x_s > (xh_s - kdpl_pkg::RIGHT_MARGIN);
    assign dir_down[1] = x_s < (xl_s + kdpl_pkg::LEFT_MARGIN);
    assign dir_down[2] = y_s < (yl_s + kdpl_pkg::VERT_MARGIN);
    assign dir_down[3] = y_s > (yh_s - kdpl_pkg::VERT_MARGIN);

    always_comb begin
        for (int k = 0; k < kdpl_pkg::NUM_DIRS; k++) begin
            dir_age[kdpl_pkg::DIR_W'(k)] =
                now_t - r_stamps[kdpl_pkg::KEY_W'(k + kdpl_pkg::NUM_BUTTONS)];
        end
    end

    always_comb begin
        n_stamps  = r_stamps;
        n_latches = r_latches;
        answer    = 1'b0;
        unique case (i_req.req_type)
            kdpl_pkg::REQ_BUTTON: begin
                // a zero stamp never locks a button out
                if (!i_req.key_index[kdpl_pkg::KEY_W-1] &&
                    !(btn_stamp != '0 && btn_age < btn_lock)) begin
                    n_stamps[i_req.key_index]  = now_t;
                    n_latches[i_req.key_index] = 1'b1;
                end
            end
            kdpl_pkg::REQ_AXIS: begin
                for (int k = 0; k < kdpl_pkg::NUM_DIRS; k++) begin
                    if (dir_down[kdpl_pkg::DIR_W'(k)] &&
                        dir_age[kdpl_pkg::DIR_W'(k)] >= axis_lock) begin
                        n_stamps[kdpl_pkg::KEY_W'(k + kdpl_pkg::NUM_BUTTONS)]  = now_t;
                        n_latches[kdpl_pkg::KEY_W'(k + kdpl_pkg::NUM_BUTTONS)] = 1'b1;
                    end
                end
            end
            kdpl_pkg::REQ_QUERY: begin
                answer = r_latches[i_req.key_index];
                // button let go too soon after its press: not a real press
                if (!i_req.key_index[kdpl_pkg::KEY_W-1] && i_req.button_level &&
                    btn_age < kdpl_pkg::QUERY_HOLD_MS) begin
                    answer = 1'b0;
                end
                n_latches[i_req.key_index] = 1'b0;
            end
            kdpl_pkg::REQ_CLEAR: begin
                n_latches = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamps  <= '{default: '0};
            r_latches <= '0;
        end else if (i_step) begin
            r_stamps  <= n_stamps;
            r_latches <= n_latches;
        end
    end

    assign o_rsp.key_was_pressed = answer;
    assign o_rsp.latch_mask      = n_latches;

endmodule

`default_nettype wire

// File: hw/rtl/key_debounce_press_latch_unit.sv
// Press qualifier for eight keys (buttons 0-3, joystick directions 4-7).
// Each input transfer yields exactly one result transfer, in order. The
// request goes into an input register, is evaluated against the stamp and
// latch state by combinational compare/subtract logic, and its result lands
// in an output register, from which it is offered and transfers when the
// output side is not stalled. One request per cycle is sustained while the
// output side is not stalled; the input register and output register let a
// new request be taken while a finished result waits. Configuration writes
// take effect at the next edge and should be made while no request is in
// flight.
`default_nettype none

module key_debounce_press_latch_unit (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [kdpl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [kdpl_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [kdpl_pkg::KEY_W-1:0]     i_key_index,
    input  wire logic                           i_button_level,
    input  wire logic [kdpl_pkg::CAL_W-1:0]     i_axis_x,
    input  wire logic [kdpl_pkg::CAL_W-1:0]     i_axis_y,
    input  wire logic [kdpl_pkg::NOW_W-1:0]     i_now_ms,
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic                           o_key_was_pressed,
    output      logic [kdpl_pkg::NUM_KEYS-1:0]  o_latch_mask
);

    kdpl_pkg::t_cfg cfg;
    kdpl_pkg::t_req r_req;
    kdpl_pkg::t_rsp core_rsp;
    kdpl_pkg::t_rsp r_rsp;
    logic r_in_valid;
    logic r_out_valid;
    logic advance;
    logic step;

    assign advance    = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && advance;
    assign o_in_ready = !r_in_valid || advance;

    kdpl_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    kdpl_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_cfg   (cfg),
        .i_req   (r_req),
        .o_rsp   (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_req.req_type     <= kdpl_pkg::t_req_type'(i_req_type);
            r_req.key_index    <= i_key_index;
            r_req.button_level <= i_button_level;
            r_req.axis_x       <= i_axis_x;
            r_req.axis_y       <= i_axis_y;
            r_req.now_ms       <= i_now_ms;
        end
        if (step) begin
            r_rsp <= core_rsp;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_key_was_pressed = r_rsp.key_was_pressed;
    assign o_latch_mask      = r_rsp.latch_mask;

endmodule

`default_nettype wire

// File: hw/rtl/kdpl_checker.sv
`default_nettype none

module kdpl_port_checks (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_ready,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_ready,
    input wire logic                           o_key_was_pressed,
    input wire logic [kdpl_pkg::NUM_KEYS-1:0]  o_latch_mask
);

    // a result held back by the sink keeps its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_latch_mask) && $stable(o_key_was_pressed))
        else $error("stalled result changed");

    // reset empties both stages
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    // a transfer taken while the result is stalled fills the last free slot
    a_full_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready && i_in_valid && o_in_ready |=>
            !o_in_ready || i_out_ready)
        else $error("accepted more than the buffering holds");

    // with no result waiting the input side is always open
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output stage");

endmodule

bind key_debounce_press_latch_unit kdpl_port_checks u_kdpl_port_checks (.*);

`default_nettype wire
